[rtl/wav_stream_sample_decoder_assert.svh]
// Assertion macros shared by the WAV stream decoder.
`ifndef WAV_STREAM_SAMPLE_DECODER_ASSERT_SVH
`define WAV_STREAM_SAMPLE_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsd check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsd check failed");

`endif

[rtl/wsd_pkg.sv]
// Types, constants and helper functions of the WAV stream decoder.
package wsd_pkg;

    localparam int unsigned MAX_SAMPLE_BYTES = 4;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] FMT_PCM   = 16'h0001;
    localparam logic [15:0] FMT_FLOAT = 16'h0003;
    localparam logic [15:0] FMT_EXT   = 16'hFFFE;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_RIFF  = 3'd1;
    localparam logic [2:0] ST_MISSING   = 3'd2;
    localparam logic [2:0] ST_ORDER     = 3'd3;
    localparam logic [2:0] ST_BAD_META  = 3'd4;
    localparam logic [2:0] ST_UNSUPP    = 3'd5;
    localparam logic [2:0] ST_TRUNCATED = 3'd6;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_file;
    } t_in_word;

    typedef struct packed {
        logic        kind;
        logic [31:0] sample_bits;
        logic [2:0]  status;
        logic [30:0] sample_rate;
        logic        last;
    } t_out_word;

    // Parser to integer conversion stage.
    typedef struct packed {
        logic        smp_vld;
        logic        is_float;
        logic [2:0]  nb;
        logic [5:0]  k;
        logic [31:0] accum;
        logic        sts_vld;
        logic [2:0]  status;
        logic [30:0] rate;
    } t_s1;

    // Integer conversion to multiply stage.
    typedef struct packed {
        logic        smp_vld;
        logic        is_float;
        logic [31:0] raw;
        logic        zero;
        logic        sign;
        logic [5:0]  ea;
        logic [23:0] ma;
        logic [5:0]  k;
        logic        sts_vld;
        logic [2:0]  status;
        logic [30:0] rate;
    } t_s2;

    // Multiply to rounding stage.
    typedef struct packed {
        logic              smp_vld;
        logic              is_float;
        logic [31:0]       raw;
        logic              zero;
        logic              sign;
        logic signed [8:0] e;
        logic [47:0]       prod;
        logic              sts_vld;
        logic [2:0]        status;
        logic [30:0]       rate;
    } t_s3;

    typedef struct packed {
        logic        smp_vld;
        logic [31:0] smp_bits;
        logic        sts_vld;
        logic [2:0]  status;
        logic [30:0] rate;
    } t_res;

    // Fraction of 1/(2^k-1) rounded to single precision, for k of 7 or more.
    // The exact value has a one every k fraction bits and never ends, so a set
    // guard bit always rounds up.
    function automatic logic [22:0] norm_frac(input logic [5:0] k);
        logic [22:0] frac;
        logic [7:0]  pos;
        logic        rnd;
        frac = '0;
        rnd  = 1'b0;
        for (int c = 1; c <= 3; c++) begin
            pos = 8'(c) * {2'b00, k};
            if (pos >= 8'd1 && pos <= 8'd23) begin
                frac = frac | (23'd1 << (8'd23 - pos));
            end
            if (pos == 8'd24) begin
                rnd = 1'b1;
            end
        end
        return frac + {22'd0, rnd};
    endfunction

endpackage

[rtl/wsd_parser.sv]
// Byte-level RIFF/WAVE chunk parser with its result register.
module wsd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_in_valid,
    input  wsd_pkg::t_in_word i_in_word,
    output wsd_pkg::t_s1     o_s1
);

    typedef enum logic [2:0] {
        PH_RIFF_TAG, PH_RIFF_SIZE, PH_WAVE_TAG, PH_CHUNK_ID,
        PH_CHUNK_SIZE, PH_BODY, PH_PAD, PH_HALT
    } t_phase;

    localparam logic [1:0] K_OTHER = 2'd0;
    localparam logic [1:0] K_FMT   = 2'd1;
    localparam logic [1:0] K_DATA  = 2'd2;
    localparam logic [1:0] K_SUB   = 2'd3;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_bp, n_bp;
    logic [31:0] r_fs, n_fs;
    logic [31:0] r_rem, n_rem;
    logic        r_pad, n_pad;
    logic [1:0]  r_kind, n_kind;
    logic [15:0] r_fmt, n_fmt;
    logic [15:0] r_ch, n_ch;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_bits, n_bits;
    logic [19:0] r_fbi, n_fbi;
    logic [31:0] r_accum, n_accum;
    logic [1:0]  r_seen, n_seen;
    logic [2:0]  r_err, n_err;
    wsd_pkg::t_s1 r_s1, n_s1;

    logic        acc;
    logic [7:0]  b;
    logic        do_end;
    logic [12:0] nb;
    logic [28:0] frame;
    logic [19:0] fbi1;

    assign acc   = i_in_valid && i_en;
    assign b     = i_in_word.byte_in;
    assign nb    = r_bits[15:3];
    assign frame = {16'd0, nb} * {13'd0, r_ch};
    assign fbi1  = r_fbi + 20'd1;

    always_comb begin
        n_phase = r_phase;
        n_bp    = r_bp;
        n_fs    = r_fs;
        n_rem   = r_rem;
        n_pad   = r_pad;
        n_kind  = r_kind;
        n_fmt   = r_fmt;
        n_ch    = r_ch;
        n_rate  = r_rate;
        n_bits  = r_bits;
        n_fbi   = r_fbi;
        n_accum = r_accum;
        n_seen  = r_seen;
        n_err   = r_err;
        do_end  = 1'b0;
        n_s1          = '0;
        n_s1.is_float = (r_fmt == wsd_pkg::FMT_FLOAT);
        n_s1.nb       = nb[2:0];
        n_s1.k        = r_bits[5:0] - 6'd1;

        if (acc) begin
            case (r_phase)
                PH_RIFF_TAG, PH_RIFF_SIZE, PH_WAVE_TAG, PH_CHUNK_ID, PH_CHUNK_SIZE: begin
                    n_fs = {b, r_fs[31:8]};
                    n_bp = r_bp + 2'd1;
                    if (r_bp == 2'd3) begin
                        case (r_phase)
                            PH_RIFF_TAG: begin
                                if (n_fs != wsd_pkg::TAG_RIFF) begin
                                    if (n_err == wsd_pkg::ST_OK) n_err = wsd_pkg::ST_BAD_RIFF;
                                    n_phase = PH_HALT;
                                end else begin
                                    n_phase = PH_RIFF_SIZE;
                                end
                            end
                            PH_RIFF_SIZE: begin
                                n_phase = PH_WAVE_TAG;
                            end
                            PH_WAVE_TAG: begin
                                if (n_fs != wsd_pkg::TAG_WAVE) begin
                                    if (n_err == wsd_pkg::ST_OK) n_err = wsd_pkg::ST_BAD_RIFF;
                                    n_phase = PH_HALT;
                                end else begin
                                    n_phase = PH_CHUNK_ID;
                                end
                            end
                            PH_CHUNK_ID: begin
                                n_kind = K_OTHER;
                                if (n_fs == wsd_pkg::TAG_FMT && !r_seen[0]) begin
                                    n_kind    = K_FMT;
                                    n_seen[0] = 1'b1;
                                end else if (n_fs == wsd_pkg::TAG_DATA && !r_seen[1]) begin
                                    n_kind = K_DATA;
                                end
                                n_phase = PH_CHUNK_SIZE;
                            end
                            default: begin
                                n_rem = n_fs;
                                n_pad = n_fs[0];
                                n_fs  = '0;
                                do_end = (n_rem == 32'd0);
                                if (n_rem != 32'd0) begin
                                    n_phase = PH_BODY;
                                end
                                if (r_kind == K_DATA) begin
                                    n_seen[1] = 1'b1;
                                    n_fbi     = '0;
                                    n_accum   = '0;
                                    if (!r_seen[0]) begin
                                        if (n_err == wsd_pkg::ST_OK) n_err = wsd_pkg::ST_ORDER;
                                        n_phase = PH_HALT;
                                    end else if (r_bits[15] || r_bits < 16'd8 ||
                                                 r_ch == 16'd0 || r_ch[15]) begin
                                        if (n_err == wsd_pkg::ST_OK) n_err = wsd_pkg::ST_BAD_META;
                                        n_phase = PH_HALT;
                                    end else if (!((r_fmt == wsd_pkg::FMT_PCM && nb >= 13'd1 &&
                                                    nb <= 13'(wsd_pkg::MAX_SAMPLE_BYTES)) ||
                                                   (r_fmt == wsd_pkg::FMT_FLOAT && nb == 13'd4 &&
                                                    wsd_pkg::MAX_SAMPLE_BYTES >= 4))) begin
                                        if (n_err == wsd_pkg::ST_OK) n_err = wsd_pkg::ST_UNSUPP;
                                        n_phase = PH_HALT;
                                    end
                                    if (n_err != wsd_pkg::ST_OK) begin
                                        do_end  = 1'b0;
                                        n_phase = PH_HALT;
                                    end
                                end
                            end
                        endcase
                    end
                end
                PH_BODY: begin
                    if (r_kind == K_DATA) begin
                        if ({7'd0, nb} > r_fbi && r_fbi < 20'd4) begin
                            n_accum[8*r_fbi[1:0] +: 8] = r_accum[8*r_fbi[1:0] +: 8] | b;
                        end
                        n_fbi = fbi1;
                        if ({9'd0, fbi1} >= frame) begin
                            n_s1.smp_vld = 1'b1;
                            n_s1.accum   = n_accum;
                            n_fbi        = '0;
                            n_accum      = '0;
                        end
                    end else if (r_kind != K_OTHER) begin
                        if (r_fs < 32'd2) begin
                            n_fmt[8*r_fs[0] +: 8] = r_fmt[8*r_fs[0] +: 8] | b;
                        end else if (r_fs < 32'd4) begin
                            n_ch[8*r_fs[0] +: 8] = r_ch[8*r_fs[0] +: 8] | b;
                        end else if (r_fs < 32'd8) begin
                            n_rate[8*r_fs[1:0] +: 8] = r_rate[8*r_fs[1:0] +: 8] | b;
                        end else if (r_fs == 32'd14 || r_fs == 32'd15) begin
                            n_bits[8*r_fs[0] +: 8] = r_bits[8*r_fs[0] +: 8] | b;
                        end else if (r_fs == 32'd24 && r_kind == K_FMT &&
                                     r_fmt == wsd_pkg::FMT_EXT) begin
                            n_fmt  = {8'd0, b};
                            n_kind = K_SUB;
                        end else if (r_fs == 32'd25 && r_kind == K_SUB) begin
                            n_fmt[15:8] = r_fmt[15:8] | b;
                        end
                    end
                    n_fs   = r_fs + 32'd1;
                    n_rem  = r_rem - 32'd1;
                    do_end = (n_rem == 32'd0);
                end
                PH_PAD: begin
                    n_pad   = 1'b0;
                    n_phase = PH_CHUNK_ID;
                end
                default: begin
                end
            endcase

            // Close the chunk; a short fmt body is a metadata error.
            if (do_end) begin
                if ((n_kind == K_FMT || n_kind == K_SUB) && n_fs < 32'd16) begin
                    if (n_err == wsd_pkg::ST_OK) n_err = wsd_pkg::ST_BAD_META;
                    n_phase = PH_HALT;
                end else begin
                    n_kind  = K_OTHER;
                    n_phase = n_pad ? PH_PAD : PH_CHUNK_ID;
                end
            end

            if (i_in_word.end_of_file) begin
                n_s1.sts_vld = 1'b1;
                n_s1.rate    = n_rate[30:0];
                if (n_err != wsd_pkg::ST_OK) begin
                    n_s1.status = n_err;
                end else if (n_phase == PH_RIFF_TAG || n_phase == PH_RIFF_SIZE ||
                             n_phase == PH_WAVE_TAG) begin
                    n_s1.status = wsd_pkg::ST_BAD_RIFF;
                end else if (n_seen != 2'b11) begin
                    n_s1.status = wsd_pkg::ST_MISSING;
                end else if (n_phase == PH_BODY && n_kind == K_DATA) begin
                    n_s1.status = wsd_pkg::ST_TRUNCATED;
                end else begin
                    n_s1.status = wsd_pkg::ST_OK;
                end
                // The decoder starts afresh for the next file.
                n_phase = PH_RIFF_TAG;
                n_bp    = '0;
                n_fs    = '0;
                n_rem   = '0;
                n_pad   = 1'b0;
                n_kind  = K_OTHER;
                n_fmt   = '0;
                n_ch    = '0;
                n_rate  = '0;
                n_bits  = '0;
                n_fbi   = '0;
                n_accum = '0;
                n_seen  = '0;
                n_err   = wsd_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RIFF_TAG;
            r_bp    <= '0;
            r_fs    <= '0;
            r_rem   <= '0;
            r_pad   <= 1'b0;
            r_kind  <= K_OTHER;
            r_fmt   <= '0;
            r_ch    <= '0;
            r_rate  <= '0;
            r_bits  <= '0;
            r_fbi   <= '0;
            r_accum <= '0;
            r_seen  <= '0;
            r_err   <= wsd_pkg::ST_OK;
            r_s1.smp_vld <= 1'b0;
            r_s1.sts_vld <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_bp    <= n_bp;
            r_fs    <= n_fs;
            r_rem   <= n_rem;
            r_pad   <= n_pad;
            r_kind  <= n_kind;
            r_fmt   <= n_fmt;
            r_ch    <= n_ch;
            r_rate  <= n_rate;
            r_bits  <= n_bits;
            r_fbi   <= n_fbi;
            r_accum <= n_accum;
            r_seen  <= n_seen;
            r_err   <= n_err;
            r_s1    <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

[rtl/wsd_i2f.sv]
// Sign conversion of a PCM word and its rounding to a single precision value.
module wsd_i2f (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  wsd_pkg::t_s1 i_s1,
    output wsd_pkg::t_s2 o_s2
);

    wsd_pkg::t_s2 r_s2, n_s2;
    logic [31:0]  s;
    logic [31:0]  mag;
    logic [31:0]  nrm;
    logic [4:0]   msb;
    logic [23:0]  top;
    logic         rnd;
    logic [24:0]  m25;

    always_comb begin
        case (i_s1.nb)
            3'd1:    s = {24'd0, i_s1.accum[7:0]} - 32'd128;
            3'd2:    s = {{16{i_s1.accum[15]}}, i_s1.accum[15:0]};
            3'd3:    s = {{8{i_s1.accum[23]}}, i_s1.accum[23:0]};
            default: s = i_s1.accum;
        endcase
        mag = s[31] ? (32'd0 - s) : s;
        msb = '0;
        for (int i = 0; i < 32; i++) begin
            if (mag[i]) msb = 5'(i);
        end
        nrm = mag << (5'd31 - msb);
        top = nrm[31:8];
        rnd = nrm[7] && ((|nrm[6:0]) || top[0]);
        m25 = {1'b0, top} + {24'd0, rnd};

        n_s2          = '0;
        n_s2.smp_vld  = i_s1.smp_vld;
        n_s2.is_float = i_s1.is_float;
        n_s2.raw      = i_s1.accum;
        n_s2.zero     = (mag == 32'd0);
        n_s2.sign     = s[31];
        n_s2.k        = i_s1.k;
        n_s2.sts_vld  = i_s1.sts_vld;
        n_s2.status   = i_s1.status;
        n_s2.rate     = i_s1.rate;
        if (m25[24]) begin
            n_s2.ma = 24'h80_0000;
            n_s2.ea = {1'b0, msb} + 6'd1;
        end else begin
            n_s2.ma = m25[23:0];
            n_s2.ea = {1'b0, msb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.smp_vld <= 1'b0;
            r_s2.sts_vld <= 1'b0;
        end else if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

[rtl/wsd_fmul.sv]
// Scaling multiply by 1/(2^(bits-1)-1) with round to nearest even.
module wsd_fmul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  wsd_pkg::t_s2  i_s2,
    output wsd_pkg::t_res o_res
);

    wsd_pkg::t_s3 r_s3, n_s3;
    logic [23:0]       mb;
    logic [23:0]       top;
    logic              g;
    logic              st;
    logic              rnd;
    logic [24:0]       m25;
    logic signed [8:0] e1;
    logic [8:0]        biased;
    logic [22:0]       frac;

    always_comb begin
        mb            = {1'b1, wsd_pkg::norm_frac(i_s2.k)};
        n_s3          = '0;
        n_s3.smp_vld  = i_s2.smp_vld;
        n_s3.is_float = i_s2.is_float;
        n_s3.raw      = i_s2.raw;
        n_s3.zero     = i_s2.zero;
        n_s3.sign     = i_s2.sign;
        n_s3.e        = $signed({3'b000, i_s2.ea}) - $signed({3'b000, i_s2.k});
        n_s3.prod     = i_s2.ma * mb;
        n_s3.sts_vld  = i_s2.sts_vld;
        n_s3.status   = i_s2.status;
        n_s3.rate     = i_s2.rate;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.smp_vld <= 1'b0;
            r_s3.sts_vld <= 1'b0;
        end else if (i_en) begin
            r_s3 <= n_s3;
        end
    end

    // The product of two normalised mantissas lies in [1, 4).
    always_comb begin
        if (r_s3.prod[47]) begin
            top = r_s3.prod[47:24];
            g   = r_s3.prod[23];
            st  = |r_s3.prod[22:0];
            e1  = r_s3.e + 9'sd1;
        end else begin
            top = r_s3.prod[46:23];
            g   = r_s3.prod[22];
            st  = |r_s3.prod[21:0];
            e1  = r_s3.e;
        end
        rnd = g && (st || top[0]);
        m25 = {1'b0, top} + {24'd0, rnd};
        if (m25[24]) begin
            e1   = e1 + 9'sd1;
            frac = '0;
        end else begin
            frac = m25[22:0];
        end
        biased = 9'(e1 + 9'sd127);

        o_res          = '0;
        o_res.smp_vld  = r_s3.smp_vld;
        o_res.sts_vld  = r_s3.sts_vld;
        o_res.status   = r_s3.status;
        o_res.rate     = r_s3.rate;
        if (r_s3.is_float) begin
            o_res.smp_bits = r_s3.raw;
        end else if (r_s3.zero) begin
            o_res.smp_bits = '0;
        end else begin
            o_res.smp_bits = {r_s3.sign, biased[7:0], frac};
        end
    end

endmodule

[rtl/wav_stream_sample_decoder.sv]
// Path: a result word passes the parser, i2f and fmul stage registers and then the output register.
// Throughput: one byte per cycle while the receiver does not stall the output; a byte
// that ends both a frame and the file stalls the input while its two words leave in turn.
// Reset (synchronous, active low) empties the pipeline and returns the parser
// to the start of a file; no clearing pass is needed.
module wav_stream_sample_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wsd_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wsd_pkg::t_out_word o_out_word
);

    wsd_pkg::t_s1  s1;
    wsd_pkg::t_s2  s2;
    wsd_pkg::t_res res;

    logic        en;
    logic        take;
    logic        r_smp_pend;
    logic        r_sts_pend;
    logic [31:0] r_smp_bits;
    logic [2:0]  r_status;
    logic [30:0] r_rate;

    assign take = o_out_valid && !i_out_stall;
    // The pipeline moves whenever the output slot will be empty after this edge.
    assign en = !(r_smp_pend || r_sts_pend) || (take && (r_smp_pend ^ r_sts_pend));
    assign o_in_stall = !en;

    wsd_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_s1       (s1)
    );

    wsd_i2f u_i2f (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_s1    (s1),
        .o_s2    (s2)
    );

    wsd_fmul u_fmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_s2    (s2),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp_pend <= 1'b0;
            r_sts_pend <= 1'b0;
        end else if (en) begin
            r_smp_pend <= res.smp_vld;
            r_sts_pend <= res.sts_vld;
            r_smp_bits <= res.smp_bits;
            r_status   <= res.status;
            r_rate     <= res.rate;
        end else if (take) begin
            r_smp_pend <= 1'b0;
        end
    end

    // A sample word leaves before the status word of the same byte.
    always_comb begin
        o_out_valid = r_smp_pend || r_sts_pend;
        o_out_word  = '0;
        if (r_smp_pend) begin
            o_out_word.kind        = wsd_pkg::KIND_SAMPLE;
            o_out_word.sample_bits = r_smp_bits;
        end else begin
            o_out_word.kind        = wsd_pkg::KIND_STATUS;
            o_out_word.status      = r_status;
            o_out_word.sample_rate = r_rate;
            o_out_word.last        = 1'b1;
        end
    end

`include "wav_stream_sample_decoder_assert.svh"

    `WSD_ASSERT_NOW(a_both_pending_stalls, i_clk, i_rst_n, r_smp_pend && r_sts_pend, o_in_stall)
    `WSD_ASSERT_NEXT(a_status_follows_sample, i_clk, i_rst_n, take && r_smp_pend && r_sts_pend, o_out_valid && o_out_word.kind == wsd_pkg::KIND_STATUS)
    `WSD_ASSERT_NOW(a_sample_word_clean, i_clk, i_rst_n, o_out_valid && o_out_word.kind == wsd_pkg::KIND_SAMPLE, o_out_word.last == 1'b0 && o_out_word.status == wsd_pkg::ST_OK)

endmodule

[verif/tb_wav_stream_sample_decoder.sv]
// Self-checking testbench of the WAV stream decoder: WAV byte streams against a bit-exact predictor.
`timescale 1ns / 100ps

module tb_wav_stream_sample_decoder;

    localparam int TARGET_BYTES = 1600;
    localparam int IDLE_LIMIT   = 5000;

    typedef enum logic [2:0] {
        PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID, PH_SIZE, PH_BODY, PH_PAD, PH_HALT
    } t_phase;

    localparam logic [1:0] CK_OTHER = 2'd0;
    localparam logic [1:0] CK_FMT   = 2'd1;
    localparam logic [1:0] CK_DATA  = 2'd2;
    localparam logic [1:0] CK_EXT   = 2'd3;

    typedef struct {
        logic [7:0] data;
        logic       eof;
        bit         typed;
        logic [2:0] status;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    wsd_pkg::t_in_word   i_in_word;
    logic                o_out_valid;
    logic                i_out_stall;
    wsd_pkg::t_out_word  o_out_word;

    wsd_pkg::t_out_word pending_words[$];
    logic [7:0] file_bytes[$];
    int         err_cnt;
    int         bytes_sent;
    int         idle_cycles;
    int         stall_hold;

    // Decoder state mirrored for prediction.
    t_phase      phase;
    logic [31:0] hdr_pos, shift_reg, remaining;
    logic        pad_due;
    logic [1:0]  kind_of_chunk;
    logic [31:0] fmt_code;
    logic [15:0] chans, depth;
    logic [31:0] rate_reg, accum;
    logic [19:0] frame_idx;
    logic [1:0]  seen;
    logic [2:0]  first_err;

    wav_stream_sample_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch in %s: got %h, expected %h", $realtime, field, got, want);
        err_cnt++;
    endtask

    // Rounds mag * 2^sc to single precision, nearest-even; sticky marks bits lost below mag.
    function automatic logic [31:0] round_f32(bit sgn, logic [63:0] mag, int sc, bit sticky);
        int          m;
        int          sh;
        logic [63:0] keep;
        bit          g;
        bit          st;
        if (mag == 64'd0) return {sgn, 31'd0};
        m = 63;
        while (!mag[m]) m--;
        if (m > 23) begin
            sh   = m - 23;
            keep = mag >> sh;
            g    = mag[sh-1];
            st   = sticky || ((mag & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0);
            if (g && (st || keep[0])) keep++;
            if (keep[24]) begin
                keep = keep >> 1;
                m++;
            end
        end else begin
            keep = mag << (23 - m);
        end
        return {sgn, 8'(m + sc + 127), keep[22:0]};
    endfunction

    function automatic logic [31:0] sample_to_f32(logic [31:0] raw);
        int          nb;
        int          k;
        int          s;
        logic [31:0] v;
        logic [63:0] d;
        logic [31:0] fs, fn;
        logic [47:0] prod;
        nb = int'(depth) / 8;
        v  = raw;
        if (fmt_code == 32'(wsd_pkg::FMT_FLOAT)) return raw;
        if (nb == 1) begin
            s = int'(v[7:0]) - 128;
        end else begin
            if (nb < 4 && v[8*nb-1]) v = v | ~((32'd1 << (8 * nb)) - 32'd1);
            s = $signed(v);
        end
        if (s == 0) return 32'd0;
        fs = round_f32(s < 0, (s < 0) ? 64'(-longint'(s)) : 64'(s), 0, 1'b0);
        k  = int'(depth) - 1;
        // Beyond 24 bits, 2^k - 1 rounds up to 2^k in single precision.
        if (k >= 25) begin
            fn = round_f32(1'b0, 64'd1, -k, 1'b0);
        end else begin
            d  = (64'd1 << k) - 64'd1;
            fn = round_f32(1'b0, (64'd1 << 62) / d, -62, ((64'd1 << 62) % d) != 64'd0);
        end
        prod = {1'b1, fs[22:0]} * {1'b1, fn[22:0]};
        return round_f32(fs[31], 64'(prod),
                         int'(fs[30:23]) + int'(fn[30:23]) - 300, 1'b0);
    endfunction

    task automatic clear_decoder();
        phase = PH_RIFF;
        hdr_pos = '0; shift_reg = '0; remaining = '0; pad_due = 1'b0;
        kind_of_chunk = CK_OTHER; fmt_code = '0; chans = '0; depth = '0;
        rate_reg = '0; accum = '0; frame_idx = '0; seen = '0; first_err = wsd_pkg::ST_OK;
    endtask

    task automatic raise(logic [2:0] code);
        if (first_err == wsd_pkg::ST_OK) first_err = code;
        phase = PH_HALT;
    endtask

    task automatic close_chunk();
        if ((kind_of_chunk == CK_FMT || kind_of_chunk == CK_EXT) && shift_reg < 32'd16) begin
            raise(wsd_pkg::ST_BAD_META);
        end else begin
            kind_of_chunk = CK_OTHER;
            phase = pad_due ? PH_PAD : PH_ID;
        end
    endtask

    task automatic check_stream_format();
        int nb;
        nb = int'(depth) / 8;
        if (depth >= 16'h8000 || depth < 16'd8 || chans == 16'd0 || chans >= 16'h8000)
            raise(wsd_pkg::ST_BAD_META);
        else if (!((fmt_code == 32'(wsd_pkg::FMT_PCM) && nb >= 1 &&
                    nb <= wsd_pkg::MAX_SAMPLE_BYTES) ||
                   (fmt_code == 32'(wsd_pkg::FMT_FLOAT) && nb == 4)))
            raise(wsd_pkg::ST_UNSUPP);
    endtask

    task automatic header_word_done();
        case (phase)
            PH_RIFF: begin
                if (shift_reg != wsd_pkg::TAG_RIFF) raise(wsd_pkg::ST_BAD_RIFF);
                else phase = PH_RSIZE;
            end
            PH_RSIZE: phase = PH_WAVE;
            PH_WAVE: begin
                if (shift_reg != wsd_pkg::TAG_WAVE) raise(wsd_pkg::ST_BAD_RIFF);
                else phase = PH_ID;
            end
            PH_ID: begin
                kind_of_chunk = CK_OTHER;
                if (shift_reg == wsd_pkg::TAG_FMT && !seen[0]) begin
                    kind_of_chunk = CK_FMT;
                    seen[0] = 1'b1;
                end else if (shift_reg == wsd_pkg::TAG_DATA && !seen[1]) begin
                    kind_of_chunk = CK_DATA;
                end
                phase = PH_SIZE;
            end
            default: begin
                remaining = shift_reg;
                pad_due   = shift_reg[0];
                shift_reg = '0;
                if (kind_of_chunk == CK_DATA) begin
                    seen[1] = 1'b1;
                    frame_idx = '0;
                    accum = '0;
                    if (!seen[0]) raise(wsd_pkg::ST_ORDER); else check_stream_format();
                end
                if (first_err == wsd_pkg::ST_OK) begin
                    if (remaining == 32'd0) close_chunk(); else phase = PH_BODY;
                end
            end
        endcase
    endtask

    task automatic fmt_body_byte(logic [31:0] off, logic [7:0] b);
        if (off < 2) fmt_code = fmt_code | (32'(b) << (8 * off));
        else if (off < 4) chans = chans | (16'(b) << (8 * (off - 2)));
        else if (off < 8) rate_reg = rate_reg | (32'(b) << (8 * (off - 4)));
        else if (off == 14 || off == 15) depth = depth | (16'(b) << (8 * (off - 14)));
        else if (off == 24 && kind_of_chunk == CK_FMT &&
                 fmt_code == 32'(wsd_pkg::FMT_EXT)) begin
            fmt_code = 32'(b);
            kind_of_chunk = CK_EXT;
        end else if (off == 25 && kind_of_chunk == CK_EXT) begin
            fmt_code = fmt_code | (32'(b) << 8);
        end
    endtask

    // Advances the mirrored decoder by one byte and queues the words it produces.
    task automatic decode_byte(wsd_pkg::t_in_word w);
        wsd_pkg::t_out_word r;
        logic [31:0] nb;
        logic [2:0]  st;
        if (phase <= PH_SIZE) begin
            shift_reg = {w.byte_in, shift_reg[31:8]};
            hdr_pos++;
            if (hdr_pos >= 4) begin
                hdr_pos = '0;
                header_word_done();
            end
        end else if (phase == PH_BODY) begin
            if (kind_of_chunk == CK_DATA) begin
                nb = 32'(depth) / 8;
                if (32'(frame_idx) < nb && frame_idx < 4)
                    accum = accum | (32'(w.byte_in) << (8 * frame_idx));
                frame_idx = frame_idx + 20'd1;
                if (32'(frame_idx) >= nb * 32'(chans)) begin
                    r = '0;
                    r.kind = wsd_pkg::KIND_SAMPLE;
                    r.sample_bits = sample_to_f32(accum);
                    pending_words.push_back(r);
                    frame_idx = '0;
                    accum = '0;
                end
            end else if (kind_of_chunk != CK_OTHER) begin
                fmt_body_byte(shift_reg, w.byte_in);
            end
            shift_reg++;
            remaining--;
            if (remaining == 0) close_chunk();
        end else if (phase == PH_PAD) begin
            pad_due = 1'b0;
            phase = PH_ID;
        end
        if (w.end_of_file) begin
            if (first_err != wsd_pkg::ST_OK) st = first_err;
            else if (phase <= PH_WAVE) st = wsd_pkg::ST_BAD_RIFF;
            else if (seen != 2'b11) st = wsd_pkg::ST_MISSING;
            else if (phase == PH_BODY && kind_of_chunk == CK_DATA) st = wsd_pkg::ST_TRUNCATED;
            else st = wsd_pkg::ST_OK;
            r = '0;
            r.kind = wsd_pkg::KIND_STATUS;
            r.status = st;
            r.sample_rate = rate_reg[30:0];
            r.last = 1'b1;
            pending_words.push_back(r);
            clear_decoder();
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(wsd_pkg::t_in_word w, int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        decode_byte(w);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic put8(logic [7:0] b);
        file_bytes.push_back(b);
    endtask

    task automatic put32(logic [31:0] v);
        for (int i = 0; i < 4; i++) put8(v[8*i +: 8]);
    endtask

    task automatic put_junk_chunk();
        int sz;
        sz = $urandom_range(0, 5);
        put32($urandom_range(0, 1) ? 32'h5453_494C : $urandom);
        put32(sz);
        repeat (sz) put8(8'($urandom));
        if (sz % 2) put8(8'($urandom));
    endtask

    // Builds one WAV file, mostly well formed, into file_bytes.
    task automatic build_file();
        int          mode, flen, nb, fsz, dsz, cut, r;
        logic [15:0] ch, bits, code;
        logic [31:0] rate;
        logic [7:0]  body[64];
        file_bytes.delete();
        mode = $urandom_range(0, 19);
        if (mode == 0) begin
            repeat ($urandom_range(1, 16)) put8(8'($urandom));
            return;
        end
        put32(mode == 1 ? 32'($urandom) : wsd_pkg::TAG_RIFF);
        put32($urandom);
        put32(mode == 2 ? 32'($urandom) : wsd_pkg::TAG_WAVE);
        if (mode == 3) begin
            put32(wsd_pkg::TAG_DATA);
            put32(32'd2);
            put8(8'($urandom));
            put8(8'($urandom));
        end
        if ($urandom_range(0, 3) == 0) put_junk_chunk();

        r = $urandom_range(0, 99);
        ch = (r < 88) ? 16'($urandom_range(1, 3)) : (r < 94) ? 16'd0 : 16'h8000 | 16'($urandom);
        case ($urandom_range(0, 11))
            0: bits = 16'd8;
            1: bits = 16'd24;
            2: bits = 16'd32;
            3: bits = 16'd12;
            4: bits = 16'd20;
            5: bits = 16'($urandom_range(0, 39));
            6: bits = 16'h8000 | 16'($urandom);
            default: bits = 16'd16;
        endcase
        r = $urandom_range(0, 10);
        code = (r < 6) ? wsd_pkg::FMT_PCM : (r < 8) ? wsd_pkg::FMT_FLOAT :
               (r < 10) ? wsd_pkg::FMT_EXT : 16'($urandom);
        if (code == wsd_pkg::FMT_FLOAT && $urandom_range(0, 3) != 0) bits = 16'd32;
        rate = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'd44100;
        r = $urandom_range(0, 9);
        if (code == wsd_pkg::FMT_EXT) flen = (r < 8) ? 40 : 24;
        else flen = (r < 6) ? 16 : (r < 8) ? 18 : (r < 9) ? 17 : $urandom_range(0, 15);
        for (int i = 0; i < 64; i++) body[i] = (i < 16 || i >= 26) ? 8'($urandom) : 8'd0;
        {body[1], body[0]} = code;
        {body[3], body[2]} = ch;
        {body[7], body[6], body[5], body[4]} = rate;
        {body[15], body[14]} = bits;
        r = $urandom_range(0, 4);
        {body[25], body[24]} = (r < 3) ? wsd_pkg::FMT_PCM :
                               (r < 4) ? wsd_pkg::FMT_FLOAT : 16'($urandom);
        put32(wsd_pkg::TAG_FMT);
        put32(flen);
        for (int i = 0; i < flen; i++) put8(body[i]);
        if (flen % 2) put8(8'($urandom));
        if ($urandom_range(0, 7) == 0) begin
            // A second fmt chunk is skipped as an ordinary chunk.
            put32(wsd_pkg::TAG_FMT);
            put32(32'd16);
            repeat (16) put8(8'($urandom));
        end
        if (mode == 4) return;

        nb  = int'(bits) / 8;
        fsz = nb * int'(ch);
        if (fsz >= 1 && fsz <= 12) begin
            dsz = $urandom_range(0, 10) * fsz;
            if ($urandom_range(0, 3) == 0) dsz += $urandom_range(0, fsz - 1);
        end else begin
            dsz = $urandom_range(0, 8);
        end
        put32(wsd_pkg::TAG_DATA);
        put32(dsz);
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, dsz) : dsz;
        repeat (cut) put8(8'($urandom));
        if (cut == dsz) begin
            if (dsz % 2) put8(8'($urandom));
            if ($urandom_range(0, 3) == 0) put_junk_chunk();
        end
        if (mode == 5) file_bytes = file_bytes[0 : $urandom_range(0, file_bytes.size() - 1)];
    endtask

    task automatic wait_for_drain();
        while (pending_words.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Receiver back-pressure: runs of stalls and runs of free flow, some of them long.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_hold  <= 0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            case ($urandom_range(0, 99)) inside
                [0:54]: begin i_out_stall <= 1'b0; stall_hold <= $urandom_range(0, 7); end
                [55:89]: begin i_out_stall <= 1'b1; stall_hold <= $urandom_range(0, 2); end
                [90:96]: begin i_out_stall <= 1'b0; stall_hold <= $urandom_range(20, 60); end
                default: begin i_out_stall <= 1'b1; stall_hold <= $urandom_range(10, 40); end
            endcase
        end
    end

    always @(posedge i_clk) begin
        wsd_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                report("unexpected word", o_out_word.sample_bits, 32'd0);
            end else begin
                want = pending_words.pop_front();
                if (o_out_word.kind != want.kind) report("kind", o_out_word.kind, want.kind);
                if (o_out_word.sample_bits != want.sample_bits)
                    report("sample_bits", o_out_word.sample_bits, want.sample_bits);
                if (o_out_word.status != want.status)
                    report("status", o_out_word.status, want.status);
                if (o_out_word.sample_rate != want.sample_rate)
                    report("sample_rate", o_out_word.sample_rate, want.sample_rate);
                if (o_out_word.last != want.last) report("last", o_out_word.last, want.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_row               rows[$];
        wsd_pkg::t_in_word  w;
        wsd_pkg::t_out_word typed_word;
        string              riff_hdr;
        err_cnt     = 0;
        bytes_sent  = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        clear_decoder();

        // A lone zero byte at end of file, a header with no chunks, a broken RIFF tag.
        rows.push_back('{8'h00, 1'b1, 1'b1, wsd_pkg::ST_BAD_RIFF});
        riff_hdr = "RIFF";
        for (int i = 0; i < 4; i++) rows.push_back('{riff_hdr[i], 1'b0, 1'b0, wsd_pkg::ST_OK});
        for (int i = 0; i < 4; i++) rows.push_back('{8'hFF, 1'b0, 1'b0, wsd_pkg::ST_OK});
        riff_hdr = "WAVE";
        for (int i = 0; i < 4; i++)
            rows.push_back('{riff_hdr[i], i == 3, i == 3, wsd_pkg::ST_MISSING});
        riff_hdr = "RIFX";
        for (int i = 0; i < 4; i++)
            rows.push_back('{riff_hdr[i], i == 3, i == 3, wsd_pkg::ST_BAD_RIFF});

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) begin
            w.byte_in = rows[i].data;
            w.end_of_file = rows[i].eof;
            send_word(w, pick_gap());
            if (rows[i].typed) begin
                typed_word = '0;
                typed_word.kind = wsd_pkg::KIND_STATUS;
                typed_word.status = rows[i].status;
                typed_word.last = 1'b1;
                pending_words[pending_words.size() - 1] = typed_word;
            end
        end
        i_in_valid <= 1'b0;
        wait_for_drain();

        while (bytes_sent < TARGET_BYTES) begin
            build_file();
            // About one file in four, picked at random, goes through without any gap on the input.
            if ($urandom_range(0, 3) == 0) begin
                foreach (file_bytes[i]) begin
                    w.byte_in = file_bytes[i];
                    w.end_of_file = (i == file_bytes.size() - 1);
                    send_word(w, 0);
                end
            end else begin
                foreach (file_bytes[i]) begin
                    w.byte_in = file_bytes[i];
                    w.end_of_file = (i == file_bytes.size() - 1);
                    send_word(w, pick_gap());
                end
            end
            if ($urandom_range(0, 7) == 0) begin
                i_in_valid <= 1'b0;
                wait_for_drain();
            end
        end
        i_in_valid <= 1'b0;

        wait_for_drain();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
